>>> sv/pvqd_pkg.sv
// ----------------------------------------------------------------------------
// pvqd_pkg
// Shared widths, limits and the result record of the index decoder.
// ----------------------------------------------------------------------------
package pvqd_pkg;

  localparam int unsigned LenW  = 4;
  localparam int unsigned KW    = 4;
  localparam int unsigned IdxW  = 35;
  localparam int unsigned CoefW = 5;
  localparam int unsigned AddrW = LenW + KW;

  typedef struct packed {
    logic signed [CoefW-1:0] coefficient;
    logic [LenW-1:0]         position;
    logic                    last_coef;
    logic                    index_error;
  } pvqd_result_t;

endpackage

>>> sv/pvqd_size_rom.sv
// ----------------------------------------------------------------------------
// pvqd_size_rom
// Codebook size table V(L,K), 16 x 16 entries, one registered read per cycle.
// ----------------------------------------------------------------------------
module pvqd_size_rom (
  input  logic                       clk_i,
  input  logic [pvqd_pkg::AddrW-1:0] rd_addr_i,
  output logic [pvqd_pkg::IdxW-1:0]  rd_data_o
);
  import pvqd_pkg::*;

  // entry index = L * 16 + K
  localparam logic [IdxW-1:0] SizeTab [256] = '{
    35'd1, 35'd0, 35'd0, 35'd0, 35'd0, 35'd0, 35'd0, 35'd0,
    35'd0, 35'd0, 35'd0, 35'd0, 35'd0, 35'd0, 35'd0, 35'd0,
    35'd1, 35'd2, 35'd2, 35'd2, 35'd2, 35'd2, 35'd2, 35'd2,
    35'd2, 35'd2, 35'd2, 35'd2, 35'd2, 35'd2, 35'd2, 35'd2,
    35'd1, 35'd4, 35'd8, 35'd12, 35'd16, 35'd20, 35'd24, 35'd28,
    35'd32, 35'd36, 35'd40, 35'd44, 35'd48, 35'd52, 35'd56, 35'd60,
    35'd1, 35'd6, 35'd18, 35'd38, 35'd66, 35'd102, 35'd146, 35'd198,
    35'd258, 35'd326, 35'd402, 35'd486, 35'd578, 35'd678, 35'd786, 35'd902,
    35'd1, 35'd8, 35'd32, 35'd88, 35'd192, 35'd360, 35'd608, 35'd952,
    35'd1408, 35'd1992, 35'd2720, 35'd3608, 35'd4672, 35'd5928, 35'd7392,
    35'd9080,
    35'd1, 35'd10, 35'd50, 35'd170, 35'd450, 35'd1002, 35'd1970, 35'd3530,
    35'd5890, 35'd9290, 35'd14002, 35'd20330, 35'd28610, 35'd39210,
    35'd52530, 35'd69002,
    35'd1, 35'd12, 35'd72, 35'd292, 35'd912, 35'd2364, 35'd5336, 35'd10836,
    35'd20256, 35'd35436, 35'd58728, 35'd93060, 35'd142000, 35'd209820,
    35'd301560, 35'd423092,
    35'd1, 35'd14, 35'd98, 35'd462, 35'd1666, 35'd4942, 35'd12642,
    35'd28814, 35'd59906, 35'd115598, 35'd209762, 35'd361550, 35'd596610,
    35'd948430, 35'd1459810, 35'd2184462,
    35'd1, 35'd16, 35'd128, 35'd688, 35'd2816, 35'd9424, 35'd27008,
    35'd68464, 35'd157184, 35'd332688, 35'd658048, 35'd1229360,
    35'd2187520, 35'd3732560, 35'd6140800, 35'd9785072,
    35'd1, 35'd18, 35'd162, 35'd978, 35'd4482, 35'd16722, 35'd53154,
    35'd148626, 35'd374274, 35'd864146, 35'd1854882, 35'd3742290,
    35'd7159170, 35'd13079250, 35'd22952610, 35'd38878482,
    35'd1, 35'd20, 35'd200, 35'd1340, 35'd6800, 35'd28004, 35'd97880,
    35'd299660, 35'd822560, 35'd2060980, 35'd4780008, 35'd10377180,
    35'd21278640, 35'd41517060, 35'd77548920, 35'd139380012,
    35'd1, 35'd22, 35'd242, 35'd1782, 35'd9922, 35'd44726, 35'd170610,
    35'd568150, 35'd1690370, 35'd4573910, 35'd11414898, 35'd26572086,
    35'd58227906, 35'd121023606, 35'd240089586, 35'd457018518,
    35'd1, 35'd24, 35'd288, 35'd2312, 35'd14016, 35'd68664, 35'd284000,
    35'd1022760, 35'd3281280, 35'd9545560, 35'd25534368, 35'd63521352,
    35'd148321344, 35'd327572856, 35'd688686048, 35'd1385794152,
    35'd1, 35'd26, 35'd338, 35'd2938, 35'd19266, 35'd101946, 35'd454610,
    35'd1761370, 35'd6065410, 35'd18892250, 35'd53972178, 35'd143027898,
    35'd354870594, 35'd830764794, 35'd1847023698, 35'd3921503898,
    35'd1, 35'd28, 35'd392, 35'd3668, 35'd25872, 35'd147084, 35'd703640,
    35'd2919620, 35'd10746400, 35'd35704060, 35'd108568488, 35'd305568564,
    35'd803467056, 35'd1989102444, 35'd4666890936, 35'd10435418532,
    35'd1, 35'd30, 35'd450, 35'd4510, 35'd34050, 35'd207006, 35'd1057730,
    35'd4680990, 35'd18347010, 35'd64797470, 35'd209070018, 35'd623207070,
    35'd1732242690, 35'd4524812190, 35'd11180805570, 35'd26283115038
  };

  logic [IdxW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= SizeTab[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/pvqd_walker.sv
// ----------------------------------------------------------------------------
// pvqd_walker
// Per-coefficient decode sequencer: walks candidate blocks against the size
// table and holds the outgoing result register.
// ----------------------------------------------------------------------------
module pvqd_walker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  logic [pvqd_pkg::LenW-1:0]  req_len_i,
  input  logic [pvqd_pkg::KW-1:0]    req_k_i,
  input  logic [pvqd_pkg::IdxW-1:0]  req_idx_i,
  output logic [pvqd_pkg::AddrW-1:0] rom_addr_o,
  input  logic [pvqd_pkg::IdxW-1:0]  rom_data_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output pvqd_pkg::pvqd_result_t     res_o
);
  import pvqd_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRange = 3'd1;
  localparam logic [2:0] StZero  = 3'd2;
  localparam logic [2:0] StPos   = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [KW-1:0]   k_q, k_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [KW-1:0]   m_q, m_d;
  logic [KW-1:0]   mag_q, mag_d;
  logic            neg_q, neg_d;
  logic            err_q, err_d;
  logic            out_valid_q, out_valid_d;
  pvqd_result_t    out_q, out_d;

  logic [LenW-1:0] rem_n;
  logic            is_last;
  logic            out_free;
  logic [IdxW:0]   blk_x2;
  logic [IdxW-1:0] idx_sub1;
  logic [IdxW-1:0] idx_sub2;
  logic [CoefW-1:0] coef_mag;

  assign rem_n    = len_q - pos_q;
  assign is_last  = (pos_q == len_q - 4'd1);
  assign out_free = !out_valid_q || res_ready_i;
  assign blk_x2   = {rom_data_i, 1'b0};
  assign idx_sub1 = idx_q - rom_data_i;
  assign idx_sub2 = idx_q - blk_x2[IdxW-1:0];
  assign coef_mag = {1'b0, mag_q};

  always_comb begin
    unique case (state_q)
      StIdle:  rom_addr_o = {req_len_i, req_k_i};
      StRange: rom_addr_o = {len_q - 4'd1, k_q};
      StZero:  rom_addr_o = {rem_n - 4'd1, k_q - 4'd1};
      StPos:   rom_addr_o = {rem_n - 4'd1, k_q - m_q - 4'd1};
      StEmit:  rom_addr_o = {rem_n - 4'd2, k_q - mag_q};
      default: rom_addr_o = {req_len_i, req_k_i};
    endcase
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    k_d         = k_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    m_d         = m_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;

    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          len_d   = req_len_i;
          k_d     = req_k_i;
          idx_d   = req_idx_i;
          pos_d   = '0;
          state_d = StRange;
        end
      end
      StRange: begin
        err_d = (idx_q >= rom_data_i);
        mag_d = '0;
        neg_d = 1'b0;
        if (len_q == '0) begin
          state_d = StIdle;
        end else if (err_d) begin
          state_d = StEmit;
        end else begin
          state_d = StZero;
        end
      end
      StZero: begin
        priority if (rem_n == 4'd1) begin
          mag_d   = k_q;
          neg_d   = (k_q != '0) && (idx_q != '0);
          state_d = StEmit;
        end else if (idx_q < rom_data_i) begin
          mag_d   = '0;
          neg_d   = 1'b0;
          state_d = StEmit;
        end else if (k_q == '0) begin
          idx_d   = idx_sub1;
          mag_d   = '0;
          neg_d   = 1'b0;
          state_d = StEmit;
        end else begin
          idx_d   = idx_sub1;
          m_d     = 4'd1;
          state_d = StPos;
        end
      end
      StPos: begin
        priority if (idx_q < rom_data_i) begin
          mag_d   = m_q;
          neg_d   = 1'b0;
          state_d = StEmit;
        end else if ({1'b0, idx_q} < blk_x2) begin
          idx_d   = idx_sub1;
          mag_d   = m_q;
          neg_d   = 1'b1;
          state_d = StEmit;
        end else if (m_q == k_q) begin
          // no candidate matched: coefficient stays zero
          idx_d   = idx_sub2;
          mag_d   = '0;
          neg_d   = 1'b0;
          state_d = StEmit;
        end else begin
          idx_d = idx_sub2;
          m_d   = m_q + 4'd1;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.coefficient       = neg_q ? -coef_mag : coef_mag;
          out_d.position          = pos_q;
          out_d.last_coef         = is_last;
          out_d.index_error       = err_q;
          k_d                     = k_q - mag_q;
          pos_d                   = pos_q + 4'd1;
          priority if (is_last) begin
            state_d = StIdle;
          end else if (!err_q) begin
            state_d = StZero;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    k_q   <= k_d;
    idx_q <= idx_d;
    pos_q <= pos_d;
    m_q   <= m_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    err_q <= err_d;
    out_q <= out_d;
  end

  assign req_ready_o = (state_q == StIdle);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

>>> sv/pvq_index_decoder_unit.sv
// ----------------------------------------------------------------------------
// pvq_index_decoder_unit
// Pyramid vector quantizer index decoder, one coefficient per result.
// ----------------------------------------------------------------------------
// Input stream: one request carries vector length L, pulse count K and a
// 35-bit codeword index. Output stream: L results, one per coefficient in
// position order, tlast on the final one, tuser set when the index is out
// of range (all coefficients zero then). A zero length gives no results.
// One request is decoded at a time; s_axis_tready is high only when the
// decoder is idle, which it is again as soon as the last result sits in the
// output register.
// Each candidate step is one read of the registered V(L,K) size table, so
// that table port sets the pace.
// When the receiver stalls, the result is held in the output register and
// the decoder waits. Reset clears the sequencer and the output valid; no
// table clearing is needed.
// ----------------------------------------------------------------------------
module pvq_index_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] vec_length, [7:4] pulse_count, [42:8] code_index, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] coefficient, [8:5] position, [15:9] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] index_error
  output logic        m_axis_tuser
);
  import pvqd_pkg::*;

  logic [AddrW-1:0] rom_addr;
  logic [IdxW-1:0]  rom_data;
  pvqd_result_t     res;

  pvqd_size_rom u_rom (
    .clk_i     (clk_i),
    .rd_addr_i (rom_addr),
    .rd_data_o (rom_data)
  );

  pvqd_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_len_i   (s_axis_tdata[3:0]),
    .req_k_i     (s_axis_tdata[7:4]),
    .req_idx_i   (s_axis_tdata[42:8]),
    .rom_addr_o  (rom_addr),
    .rom_data_i  (rom_data),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'd0, res.position, res.coefficient};
  assign m_axis_tlast = res.last_coef;
  assign m_axis_tuser = res.index_error;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[4:0] == 5'd0)
    else $error("error result with nonzero coefficient");

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while decoding");

  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[4:0] != 5'b10000)
    else $error("coefficient out of range");
`endif

endmodule
